FILE: rtl/core/lif_pkg.sv
// ----------------------------------------------------------------------------
// lif_pkg
// Shared constants and types for the life automaton step block.
// ----------------------------------------------------------------------------
package lif_pkg;
  localparam int GRID_COLS = 64;
  localparam int GRID_ROWS = 32;
  localparam int COL_W = 6;
  localparam int ROW_W = 5;
  localparam int CMD_W = 2;

  localparam logic [CMD_W-1:0] CMD_READ    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd2;
  // Unused code: behaves as a read
  localparam logic [CMD_W-1:0] CMD_SPARE   = 2'd3;

  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] STAY_LOW    = 4'd2;
  localparam logic [3:0] STAY_HIGH   = 4'd3;

  // Input item payload
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } cmd_item_t;

  // Result item payload
  typedef struct packed {
    logic cell_alive;
  } cell_result_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture command and address
    logic set_cell;  // write addressed cell alive
    logic step_gen;  // advance every cell one generation
    logic show;      // register the addressed cell into the result
  } lif_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
  } lif_stat_t;
endpackage

FILE: rtl/core/lif_stream_if.sv
// ----------------------------------------------------------------------------
// lif_stream_if
// Valid/ready channel carrying one item payload.
// ----------------------------------------------------------------------------
interface lif_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/lif_datapath.sv
// ----------------------------------------------------------------------------
// lif_datapath
// Cell array with per-cell neighbor counting and the addressed-cell readout.
// ----------------------------------------------------------------------------
module lif_datapath import lif_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  lif_cmd_t         ctl,
  input  logic [CMD_W-1:0] in_cmd,
  input  logic [COL_W-1:0] in_col,
  input  logic [ROW_W-1:0] in_row,
  output lif_stat_t        stat,
  output logic             cell_alive
);
  logic [GRID_COLS-1:0] grid [GRID_ROWS];
  logic [GRID_COLS-1:0] grid_next [GRID_ROWS];
  logic [CMD_W-1:0] cmd;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic in_grid;

  assign stat.cmd = cmd;
  assign in_grid = ({1'b0, col} < (COL_W+1)'(GRID_COLS)) &&
                   ({1'b0, row} < (ROW_W+1)'(GRID_ROWS));

  // One cell rule per cell; neighbors beyond the edge read as dead.
  always_comb begin
    for (int r = 0; r < GRID_ROWS; r++) begin
      for (int c = 0; c < GRID_COLS; c++) begin
        logic [3:0] n;
        n = 4'd0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < GRID_ROWS &&
                c + dc >= 0 && c + dc < GRID_COLS) begin
              n = n + 4'(grid[r+dr][c+dc]);
            end
          end
        end
        if (grid[r][c]) grid_next[r][c] = (n >= STAY_LOW) && (n <= STAY_HIGH);
        else            grid_next[r][c] = (n == BIRTH_COUNT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd <= in_cmd;
      col <= in_col;
      row <= in_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < GRID_ROWS; r++) grid[r] <= '0;
      cell_alive <= 1'b0;
    end else begin
      if (ctl.step_gen) begin
        for (int r = 0; r < GRID_ROWS; r++) grid[r] <= grid_next[r];
      end else if (ctl.set_cell && in_grid) begin
        grid[row[ROW_W-1:0]][col[COL_W-1:0]] <= 1'b1;
      end
      if (ctl.show) cell_alive <= in_grid && grid[row][col];
    end
  end
endmodule

FILE: rtl/core/lif_ctrl.sv
// ----------------------------------------------------------------------------
// lif_ctrl
// Sequencer: take an item, apply it, show the cell, hand off the result.
// ----------------------------------------------------------------------------
module lif_ctrl import lif_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  lif_stat_t stat,
  output lif_cmd_t  ctl
);
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_APPLY = 2'd1;
  localparam logic [1:0] ST_SHOW  = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [1:0] state, state_next;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);

  always_comb begin
    ctl = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        ctl.load = in_valid;
        if (in_valid) state_next = ST_APPLY;
      end
      ST_APPLY: begin
        ctl.set_cell = (stat.cmd == CMD_SET);
        ctl.step_gen = (stat.cmd == CMD_ADVANCE);
        state_next = ST_SHOW;
      end
      ST_SHOW: begin
        ctl.show = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

`ifndef NO_ASSERTIONS
  a_show_after_apply: assert property (@(posedge clk) disable iff (rst)
    ctl.show |-> $past(state) == ST_APPLY) else $error("show without apply");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
`endif
endmodule

FILE: rtl/core/life_automaton_step.sv
// ----------------------------------------------------------------------------
// life_automaton_step
// B3/S23 cellular automaton on a bounded 64 x 32 grid, edges dead.
// ----------------------------------------------------------------------------
// channel | dir | payload
// in_ch   | in  | cmd[1:0], col[5:0], row[4:0]
// out_ch  | out | cell_alive
//
// Each item goes through accept, apply, read the cell and hand off, in that order.
// An advance updates every cell at once through per-cell neighbor counters.
// Reset clears all cells dead and idles the sequencer.
// A stalled result holds in its register; no new item is taken meanwhile.
module life_automaton_step import lif_pkg::*; (
  input logic clk,
  input logic rst,
  lif_stream_if.sink   in_ch,
  lif_stream_if.source out_ch
);
  lif_cmd_t  ctl;
  lif_stat_t stat;

  // Sequencer: owns the handshakes.
  lif_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat(stat), .ctl(ctl)
  );

  // Cell array and result register.
  lif_datapath u_dp (
    .clk(clk), .rst(rst), .ctl(ctl),
    .in_cmd(in_ch.data.cmd), .in_col(in_ch.data.col), .in_row(in_ch.data.row),
    .stat(stat), .cell_alive(out_ch.data.cell_alive)
  );
endmodule
